[rtl/core/gal_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gal_pkg
// Types and constants shared by the glyph atlas text layout block: character
// codes, atlas geometry, the glyph width table and the decoded glyph record.
// ----------------------------------------------------------------------------
package gal_pkg;

   localparam int CHAR_BITS     = 8;
   localparam int START_BITS    = 16;
   localparam int ATLAS_POS_BITS = 7;
   localparam int GLYPH_W_BITS  = 4;
   localparam int CELL_IDX_BITS = 6;
   localparam int GLYPH_COUNT   = 64;
   localparam int SIZE_BITS     = 8;
   localparam int LINE_STEP_BITS = 9;
   localparam int DROP_BITS     = 6;

   localparam logic [CHAR_BITS-1:0] CHAR_NEWLINE = 8'd10;
   localparam logic [CHAR_BITS-1:0] CHAR_SPACE   = 8'd32;
   localparam logic [CHAR_BITS-1:0] CHAR_BANG    = 8'd33;
   localparam logic [CHAR_BITS-1:0] CHAR_DOT     = 8'd46;
   localparam logic [CHAR_BITS-1:0] CHAR_ZERO    = 8'd48;
   localparam logic [CHAR_BITS-1:0] CHAR_ONE     = 8'd49;
   localparam logic [CHAR_BITS-1:0] CHAR_NINE    = 8'd57;
   localparam logic [CHAR_BITS-1:0] CHAR_UP_A    = 8'd65;
   localparam logic [CHAR_BITS-1:0] CHAR_UP_Z    = 8'd90;
   localparam logic [CHAR_BITS-1:0] CHAR_LO_A    = 8'd97;
   localparam logic [CHAR_BITS-1:0] CHAR_LO_G    = 8'd103;
   localparam logic [CHAR_BITS-1:0] CHAR_LO_J    = 8'd106;
   localparam logic [CHAR_BITS-1:0] CHAR_LO_P    = 8'd112;
   localparam logic [CHAR_BITS-1:0] CHAR_LO_Q    = 8'd113;
   localparam logic [CHAR_BITS-1:0] CHAR_LO_Y    = 8'd121;
   localparam logic [CHAR_BITS-1:0] CHAR_LO_Z    = 8'd122;

   // Atlas cell index of the first entry of each character run.
   localparam logic [CELL_IDX_BITS-1:0] CELL_UPPER = 6'd0;
   localparam logic [CELL_IDX_BITS-1:0] CELL_DIGIT = 6'd26;
   localparam logic [CELL_IDX_BITS-1:0] CELL_ZERO  = 6'd35;
   localparam logic [CELL_IDX_BITS-1:0] CELL_BANG  = 6'd36;
   localparam logic [CELL_IDX_BITS-1:0] CELL_DOT   = 6'd37;
   localparam logic [CELL_IDX_BITS-1:0] CELL_LOWER = 6'd38;

   localparam logic [ATLAS_POS_BITS-1:0] SPACE_SRC_X = 7'd85;
   localparam logic [ATLAS_POS_BITS-1:0] SPACE_SRC_Y = 7'd64;
   localparam logic [GLYPH_W_BITS-1:0]   SPACE_W     = 4'd7;

   localparam logic [GLYPH_W_BITS-1:0] GLYPH_WIDTH [GLYPH_COUNT] = '{
      4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15,
      4'd8,  4'd14, 4'd14, 4'd14, 4'd15, 4'd15, 4'd15, 4'd15,
      4'd15, 4'd15, 4'd15, 4'd14, 4'd14, 4'd15, 4'd15, 4'd13,
      4'd14, 4'd15, 4'd9,  4'd13, 4'd13, 4'd12, 4'd13, 4'd13,
      4'd12, 4'd13, 4'd13, 4'd13, 4'd6,  4'd6,  4'd12, 4'd12,
      4'd11, 4'd12, 4'd12, 4'd10, 4'd11, 4'd12, 4'd6,  4'd10,
      4'd11, 4'd6,  4'd14, 4'd11, 4'd12, 4'd12, 4'd12, 4'd11,
      4'd11, 4'd9,  4'd11, 4'd11, 4'd15, 4'd11, 4'd12, 4'd11
   };

   typedef enum logic [1:0] {
      DROP_NONE,
      DROP_FOUR,
      DROP_THREE
   } drop_kind_type;

   typedef struct packed {
      logic                      known;
      logic [ATLAS_POS_BITS-1:0] src_x;
      logic [ATLAS_POS_BITS-1:0] src_y;
      logic [GLYPH_W_BITS-1:0]   src_w;
      drop_kind_type             drop;
   } glyph_info_type;

endpackage : gal_pkg
`default_nettype wire

[rtl/core/gal_req_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gal_req_if
// Character request channel: valid/ready handshake with the character code
// and the optional text start position.
// ----------------------------------------------------------------------------
interface gal_req_if
   import gal_pkg::*;
();
   logic                         valid;
   logic                         ready;
   logic [CHAR_BITS-1:0]         char_code;
   logic                         first_of_text;
   logic signed [START_BITS-1:0] start_x;
   logic signed [START_BITS-1:0] start_y;

   modport source (output valid, output char_code, output first_of_text,
                   output start_x, output start_y, input ready);
   modport sink   (input valid, input char_code, input first_of_text,
                   input start_x, input start_y, output ready);
endinterface : gal_req_if
`default_nettype wire

[rtl/core/gal_rsp_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gal_rsp_if
// Glyph placement response channel: valid/ready handshake with the atlas
// source rectangle and the destination rectangle.
// ----------------------------------------------------------------------------
interface gal_rsp_if
   import gal_pkg::*;
#(
   parameter int COORD_BITS = 16
) ();
   logic                         valid;
   logic                         ready;
   logic [ATLAS_POS_BITS-1:0]    src_x;
   logic [ATLAS_POS_BITS-1:0]    src_y;
   logic [GLYPH_W_BITS-1:0]      src_w;
   logic signed [COORD_BITS-1:0] dst_x;
   logic signed [COORD_BITS-1:0] dst_y;
   logic [SIZE_BITS-1:0]         dst_w;
   logic [SIZE_BITS-1:0]         dst_h;

   modport source (output valid, output src_x, output src_y, output src_w,
                   output dst_x, output dst_y, output dst_w, output dst_h,
                   input ready);
   modport sink   (input valid, input src_x, input src_y, input src_w,
                   input dst_x, input dst_y, input dst_w, input dst_h,
                   output ready);
endinterface : gal_rsp_if
`default_nettype wire

[rtl/core/gal_glyph_decode.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gal_glyph_decode
// Maps a character code to its atlas cell, atlas width and descender class.
// Codes without a glyph come back with known cleared.
// ----------------------------------------------------------------------------
module gal_glyph_decode
   import gal_pkg::*;
(
   input  wire logic [CHAR_BITS-1:0] char_code,
   output glyph_info_type            glyph
);

   logic                     in_cell;
   logic [CELL_IDX_BITS-1:0] cell_idx;

   always_comb begin
      in_cell  = 1'b1;
      cell_idx = '0;
      if (char_code >= CHAR_UP_A && char_code <= CHAR_UP_Z) begin
         cell_idx = CELL_UPPER + CELL_IDX_BITS'(char_code - CHAR_UP_A);
      end else if (char_code >= CHAR_ONE && char_code <= CHAR_NINE) begin
         cell_idx = CELL_DIGIT + CELL_IDX_BITS'(char_code - CHAR_ONE);
      end else if (char_code >= CHAR_LO_A && char_code <= CHAR_LO_Z) begin
         cell_idx = CELL_LOWER + CELL_IDX_BITS'(char_code - CHAR_LO_A);
      end else if (char_code == CHAR_ZERO) begin
         cell_idx = CELL_ZERO;
      end else if (char_code == CHAR_BANG) begin
         cell_idx = CELL_BANG;
      end else if (char_code == CHAR_DOT) begin
         cell_idx = CELL_DOT;
      end else begin
         in_cell = 1'b0;
      end
   end

   always_comb begin
      glyph.known = in_cell;
      // Eight cells of sixteen pixels per atlas row.
      glyph.src_x = {cell_idx[2:0], 4'b0000};
      glyph.src_y = {cell_idx[5:3], 4'b0000};
      glyph.src_w = GLYPH_WIDTH[cell_idx];
      if (char_code == CHAR_SPACE) begin
         glyph.known = 1'b1;
         glyph.src_x = SPACE_SRC_X;
         glyph.src_y = SPACE_SRC_Y;
         glyph.src_w = SPACE_W;
      end else if (!in_cell) begin
         glyph.src_x = '0;
         glyph.src_y = '0;
         glyph.src_w = '0;
      end
      case (char_code)
         CHAR_LO_P, CHAR_LO_Q, CHAR_LO_Y, CHAR_LO_G: glyph.drop = DROP_FOUR;
         CHAR_LO_J:                                  glyph.drop = DROP_THREE;
         default:                                    glyph.drop = DROP_NONE;
      endcase
   end

endmodule : gal_glyph_decode
`default_nettype wire

[rtl/core/glyph_atlas_text_layout_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// glyph_atlas_text_layout_top
// Places a stream of characters: keeps the pen and line start, looks each
// glyph up in the atlas and emits its source and scaled destination rectangles.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake          Carries
//   req_if   in         valid/ready        char_code, first_of_text, start_x/y
//   rsp_if   out        valid/ready        src_x/y/w, dst_x/y/w/h
//   csr      in         csr_we, no wait    scale, Q4.SCALE_FRAC_BITS
//
// One request per cycle is taken while req_if.ready is high. A request waits
// in the input register, where the glyph lookup, the width-by-scale and
// constant-by-scale multiplies and the pen add run, and the result is then
// registered in the output register. Reset clears the pen, the line start and
// the valid flags and loads a scale of one. A stalled response holds the input
// register, and req_if.ready drops only while both registers are full and rsp_if
// is stalled. Characters without a glyph, and newline, give no response.
// ----------------------------------------------------------------------------
module glyph_atlas_text_layout_top
   import gal_pkg::*;
#(
   parameter int COORD_BITS      = 16,
   parameter int SCALE_FRAC_BITS = 8
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   gal_req_if.sink                           req_if,
   gal_rsp_if.source                         rsp_if,
   input  wire logic                         csr_we,
   input  wire logic [SCALE_FRAC_BITS+3:0]   csr_wdata
);

   localparam int SCALE_BITS = SCALE_FRAC_BITS + 4;
   // Working width: holds a start position or a pen plus one increment.
   localparam int WB = ((COORD_BITS > START_BITS) ? COORD_BITS : START_BITS) + 2;
   localparam logic signed [WB-1:0] COORD_MAX =
      WB'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
   localparam logic signed [WB-1:0] COORD_MIN = -COORD_MAX - WB'(1);
   localparam int PROD_BITS = SCALE_BITS + 5;

   function automatic logic signed [WB-1:0] coord_sat(input logic signed [WB-1:0] v);
      logic signed [WB-1:0] r;
      r = v;
      if (v > COORD_MAX) begin
         r = COORD_MAX;
      end else if (v < COORD_MIN) begin
         r = COORD_MIN;
      end
      return r;
   endfunction

   // Scale register
   logic [SCALE_BITS-1:0] scale_ff, scale_in;

   always_comb begin
      scale_in = csr_we ? csr_wdata : scale_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_BITS'(1) << SCALE_FRAC_BITS;
      end else begin
         scale_ff <= scale_in;
      end
   end

   // Input register
   logic                         s1_valid_ff, s1_valid_in;
   logic [CHAR_BITS-1:0]         s1_char_ff, s1_char_in;
   logic                         s1_first_ff, s1_first_in;
   logic signed [START_BITS-1:0] s1_start_x_ff, s1_start_x_in;
   logic signed [START_BITS-1:0] s1_start_y_ff, s1_start_y_in;

   logic out_free;
   logic s1_fire;
   logic req_take;

   assign out_free        = !rsp_if.valid || rsp_if.ready;
   assign s1_fire         = s1_valid_ff && out_free;
   assign req_if.ready    = !s1_valid_ff || out_free;
   assign req_take        = req_if.valid && req_if.ready;

   always_comb begin
      s1_valid_in   = s1_valid_ff;
      s1_char_in    = s1_char_ff;
      s1_first_in   = s1_first_ff;
      s1_start_x_in = s1_start_x_ff;
      s1_start_y_in = s1_start_y_ff;
      if (req_take) begin
         s1_valid_in   = 1'b1;
         s1_char_in    = req_if.char_code;
         s1_first_in   = req_if.first_of_text;
         s1_start_x_in = req_if.start_x;
         s1_start_y_in = req_if.start_y;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_char_ff    <= s1_char_in;
      s1_first_ff   <= s1_first_in;
      s1_start_x_ff <= s1_start_x_in;
      s1_start_y_ff <= s1_start_y_in;
   end

   // Glyph lookup
   glyph_info_type glyph;

   gal_glyph_decode u_decode (
      .char_code (s1_char_ff),
      .glyph     (glyph)
   );

   // Scaled sizes: n scaled is floor(n * scale / 2^SCALE_FRAC_BITS).
   logic [PROD_BITS-1:0]      w_prod, h_prod, line_prod, d4_prod, d3_prod;
   logic [SIZE_BITS-1:0]      w_scaled, h_scaled;
   logic [LINE_STEP_BITS-1:0] line_step;
   logic [DROP_BITS-1:0]      drop_scaled;

   always_comb begin
      w_prod    = PROD_BITS'(glyph.src_w) * PROD_BITS'(scale_ff);
      h_prod    = PROD_BITS'(scale_ff) * PROD_BITS'(15);
      line_prod = PROD_BITS'(scale_ff) * PROD_BITS'(20);
      d4_prod   = PROD_BITS'(scale_ff) << 2;
      d3_prod   = PROD_BITS'(scale_ff) * PROD_BITS'(3);
      w_scaled  = w_prod[SCALE_FRAC_BITS+SIZE_BITS-1:SCALE_FRAC_BITS];
      h_scaled  = h_prod[SCALE_FRAC_BITS+SIZE_BITS-1:SCALE_FRAC_BITS];
      line_step = line_prod[SCALE_FRAC_BITS+LINE_STEP_BITS-1:SCALE_FRAC_BITS];
      case (glyph.drop)
         DROP_FOUR:  drop_scaled = d4_prod[SCALE_FRAC_BITS+DROP_BITS-1:SCALE_FRAC_BITS];
         DROP_THREE: drop_scaled = d3_prod[SCALE_FRAC_BITS+DROP_BITS-1:SCALE_FRAC_BITS];
         default:    drop_scaled = '0;
      endcase
   end

   // Pen state
   logic signed [COORD_BITS-1:0] pen_x_ff, pen_x_in;
   logic signed [COORD_BITS-1:0] pen_y_ff, pen_y_in;
   logic signed [COORD_BITS-1:0] line_x_ff, line_x_in;

   logic signed [WB-1:0] base_x, base_y, base_line;
   logic signed [WB-1:0] adv_x, down_y, drop_y;
   logic                 is_newline;
   logic                 emit;

   always_comb begin
      // A first character reloads the pen before it is handled.
      if (s1_first_ff) begin
         base_x = coord_sat(WB'(s1_start_x_ff));
         base_y = coord_sat(WB'(s1_start_y_ff));
      end else begin
         base_x = WB'(pen_x_ff);
         base_y = WB'(pen_y_ff);
      end
      base_line  = s1_first_ff ? base_x : WB'(line_x_ff);
      adv_x      = coord_sat(base_x + signed'(WB'(w_scaled)));
      down_y     = coord_sat(base_y + signed'(WB'(line_step)));
      drop_y     = coord_sat(base_y + signed'(WB'(drop_scaled)));
      is_newline = (s1_char_ff == CHAR_NEWLINE);
      emit       = glyph.known && !is_newline;
   end

   always_comb begin
      pen_x_in  = pen_x_ff;
      pen_y_in  = pen_y_ff;
      line_x_in = line_x_ff;
      if (s1_fire) begin
         pen_x_in  = COORD_BITS'(base_x);
         pen_y_in  = COORD_BITS'(base_y);
         line_x_in = COORD_BITS'(base_line);
         if (is_newline) begin
            pen_x_in = COORD_BITS'(base_line);
            pen_y_in = COORD_BITS'(down_y);
         end else if (emit) begin
            pen_x_in = COORD_BITS'(adv_x);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_x_ff  <= '0;
         pen_y_ff  <= '0;
         line_x_ff <= '0;
      end else begin
         pen_x_ff  <= pen_x_in;
         pen_y_ff  <= pen_y_in;
         line_x_ff <= line_x_in;
      end
   end

   // Output register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [ATLAS_POS_BITS-1:0]    rsp_src_x_ff, rsp_src_x_in;
   logic [ATLAS_POS_BITS-1:0]    rsp_src_y_ff, rsp_src_y_in;
   logic [GLYPH_W_BITS-1:0]      rsp_src_w_ff, rsp_src_w_in;
   logic signed [COORD_BITS-1:0] rsp_dst_x_ff, rsp_dst_x_in;
   logic signed [COORD_BITS-1:0] rsp_dst_y_ff, rsp_dst_y_in;
   logic [SIZE_BITS-1:0]         rsp_dst_w_ff, rsp_dst_w_in;
   logic [SIZE_BITS-1:0]         rsp_dst_h_ff, rsp_dst_h_in;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_src_x_in = rsp_src_x_ff;
      rsp_src_y_in = rsp_src_y_ff;
      rsp_src_w_in = rsp_src_w_ff;
      rsp_dst_x_in = rsp_dst_x_ff;
      rsp_dst_y_in = rsp_dst_y_ff;
      rsp_dst_w_in = rsp_dst_w_ff;
      rsp_dst_h_in = rsp_dst_h_ff;
      if (s1_fire && emit) begin
         rsp_valid_in = 1'b1;
         rsp_src_x_in = glyph.src_x;
         rsp_src_y_in = glyph.src_y;
         rsp_src_w_in = glyph.src_w;
         rsp_dst_x_in = COORD_BITS'(base_x);
         rsp_dst_y_in = COORD_BITS'(drop_y);
         rsp_dst_w_in = w_scaled;
         rsp_dst_h_in = h_scaled;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_src_x_ff <= rsp_src_x_in;
      rsp_src_y_ff <= rsp_src_y_in;
      rsp_src_w_ff <= rsp_src_w_in;
      rsp_dst_x_ff <= rsp_dst_x_in;
      rsp_dst_y_ff <= rsp_dst_y_in;
      rsp_dst_w_ff <= rsp_dst_w_in;
      rsp_dst_h_ff <= rsp_dst_h_in;
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.src_x = rsp_src_x_ff;
   assign rsp_if.src_y = rsp_src_y_ff;
   assign rsp_if.src_w = rsp_src_w_ff;
   assign rsp_if.dst_x = rsp_dst_x_ff;
   assign rsp_if.dst_y = rsp_dst_y_ff;
   assign rsp_if.dst_w = rsp_dst_w_ff;
   assign rsp_if.dst_h = rsp_dst_h_ff;

endmodule : glyph_atlas_text_layout_top
`default_nettype wire

[test/tb_glyph_atlas_text_layout_top.sv]
// ----------------------------------------------------------------------------
// tb_glyph_atlas_text_layout_top
// Self-checking bench for the glyph atlas text layout block. A short table of
// hand-picked characters runs first. It covers atlas corners, descenders,
// newline, ignored codes, text starts and coordinate saturation. Random texts
// and noise follow, under several render scales and with idle cycles on
// either channel. A predictor in the bench tracks the pen and checks every
// placement field by field.
// ----------------------------------------------------------------------------
module tb_glyph_atlas_text_layout_top;
   import gal_pkg::*;

   localparam int COORD_W         = 16;
   localparam int FRAC_W          = 8;
   localparam int SCALE_W         = FRAC_W + 4;
   localparam int HALF_PERIOD     = 5;
   localparam int RESET_CYCLES    = 6;
   localparam int DRAIN_CYCLES    = 4;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int PHASE_COUNT     = 8;
   localparam int ITEMS_PER_PHASE = 150;
   localparam int SCALE_ONE       = 1 << FRAC_W;
   localparam int SCALE_MAX       = (1 << SCALE_W) - 1;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct packed {
      logic [ATLAS_POS_BITS-1:0] src_x;
      logic [ATLAS_POS_BITS-1:0] src_y;
      logic [GLYPH_W_BITS-1:0]   src_w;
      logic signed [COORD_W-1:0] dst_x;
      logic signed [COORD_W-1:0] dst_y;
      logic [SIZE_BITS-1:0]      dst_w;
      logic [SIZE_BITS-1:0]      dst_h;
   } placement_type;

   typedef struct packed {
      logic [CHAR_BITS-1:0]      code;
      logic                      first;
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
      logic                      typed;
      placement_type             want;
   } char_row_type;

   // Atlas cells in order, eight to a row, sixteen pixels apart.
   localparam logic [8*GLYPH_COUNT-1:0] ATLAS_CHARS =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZ1234567890!.abcdefghijklmnopqrstuvwxyz";

   localparam logic [GLYPH_W_BITS-1:0] CELL_WIDTH [GLYPH_COUNT] = '{
      4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15,
      4'd8,  4'd14, 4'd14, 4'd14, 4'd15, 4'd15, 4'd15, 4'd15,
      4'd15, 4'd15, 4'd15, 4'd14, 4'd14, 4'd15, 4'd15, 4'd13,
      4'd14, 4'd15, 4'd9,  4'd13, 4'd13, 4'd12, 4'd13, 4'd13,
      4'd12, 4'd13, 4'd13, 4'd13, 4'd6,  4'd6,  4'd12, 4'd12,
      4'd11, 4'd12, 4'd12, 4'd10, 4'd11, 4'd12, 4'd6,  4'd10,
      4'd11, 4'd6,  4'd14, 4'd11, 4'd12, 4'd12, 4'd12, 4'd11,
      4'd11, 4'd9,  4'd11, 4'd11, 4'd15, 4'd11, 4'd12, 4'd11
   };

   // Directed characters, all at the reset scale of one. Placements are typed
   // in where they follow directly from the atlas and the pen.
   localparam char_row_type DIRECTED [25] = '{
      '{CHAR_UP_A,   1'b0, 16'sd0, 16'sd0, 1'b1,
        '{7'd0, 7'd0, 4'd15, 16'sd0, 16'sd0, 8'd15, 8'd15}},
      '{"B",         1'b0, 16'sd0, 16'sd0, 1'b1,
        '{7'd16, 7'd0, 4'd15, 16'sd15, 16'sd0, 8'd15, 8'd15}},
      '{CHAR_NEWLINE, 1'b0, 16'sd0, 16'sd0, 1'b0, '0},
      '{CHAR_UP_Z,   1'b0, 16'sd0, 16'sd0, 1'b1,
        '{7'd16, 7'd48, 4'd15, 16'sd0, 16'sd20, 8'd15, 8'd15}},
      '{CHAR_LO_P,   1'b1, 16'sd100, 16'sd200, 1'b1,
        '{7'd80, 7'd96, 4'd12, 16'sd100, 16'sd204, 8'd12, 8'd15}},
      '{CHAR_LO_J,   1'b0, 16'sd0, 16'sd0, 1'b1,
        '{7'd112, 7'd80, 4'd10, 16'sd112, 16'sd203, 8'd10, 8'd15}},
      '{CHAR_SPACE,  1'b0, 16'sd0, 16'sd0, 1'b1,
        '{7'd85, 7'd64, 4'd7, 16'sd122, 16'sd200, 8'd7, 8'd15}},
      '{CHAR_BANG,   1'b0, 16'sd0, 16'sd0, 1'b1,
        '{7'd64, 7'd64, 4'd6, 16'sd129, 16'sd200, 8'd6, 8'd15}},
      '{CHAR_NEWLINE, 1'b0, 16'sd0, 16'sd0, 1'b0, '0},
      '{CHAR_DOT,    1'b0, 16'sd0, 16'sd0, 1'b1,
        '{7'd80, 7'd64, 4'd6, 16'sd100, 16'sd220, 8'd6, 8'd15}},
      '{8'd0,        1'b0, 16'sd0, 16'sd0, 1'b0, '0},
      '{8'd255,      1'b1, -16'sd5, 16'sd7, 1'b0, '0},
      '{"x",         1'b0, 16'sd0, 16'sd0, 1'b0, '0},
      '{"W",         1'b1, 16'sh7FFF, 16'sh8000, 1'b1,
        '{7'd96, 7'd32, 4'd15, 16'sh7FFF, 16'sh8000, 8'd15, 8'd15}},
      '{"M",         1'b0, 16'sd0, 16'sd0, 1'b1,
        '{7'd64, 7'd16, 4'd15, 16'sh7FFF, 16'sh8000, 8'd15, 8'd15}},
      '{CHAR_LO_Y,   1'b1, 16'sh8000, 16'sh7FFF, 1'b1,
        '{7'd96, 7'd112, 4'd12, 16'sh8000, 16'sh7FFF, 8'd12, 8'd15}},
      '{CHAR_NEWLINE, 1'b0, 16'sd0, 16'sd0, 1'b0, '0},
      '{CHAR_LO_G,   1'b0, 16'sd0, 16'sd0, 1'b0, '0},
      '{CHAR_LO_Q,   1'b0, 16'sd0, 16'sd0, 1'b0, '0},
      '{CHAR_ZERO,   1'b0, 16'sd0, 16'sd0, 1'b0, '0},
      '{CHAR_NINE,   1'b0, 16'sd0, 16'sd0, 1'b0, '0},
      '{CHAR_LO_Z,   1'b0, 16'sd0, 16'sd0, 1'b0, '0},
      '{8'd127,      1'b0, 16'sd0, 16'sd0, 1'b0, '0},
      '{CHAR_NEWLINE, 1'b1, 16'sh8000, 16'sh8000, 1'b0, '0},
      '{CHAR_LO_A,   1'b0, 16'sd0, 16'sd0, 1'b0, '0}
   };

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_we;
   logic [SCALE_W-1:0]   csr_wdata;

   // Bench copy of the layout state.
   logic signed [COORD_W-1:0] pen_x;
   logic signed [COORD_W-1:0] pen_y;
   logic signed [COORD_W-1:0] line_x;
   logic [SCALE_W-1:0]        scale;

   placement_type placements [$];
   idle_mode_type idle_mode = IDLE_NONE;
   int            accepted_requests = 0;
   int            layout_items = 0;
   int            newlines = 0;
   int            placements_checked = 0;
   int            mismatches = 0;
   int            quiet_cycles = 0;

   gal_req_if req_if ();
   gal_rsp_if #(.COORD_BITS(COORD_W)) rsp_if ();

   glyph_atlas_text_layout_top #(
      .COORD_BITS      (COORD_W),
      .SCALE_FRAC_BITS (FRAC_W)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   function automatic int scaled_by(input int n);
      return (n * int'(scale)) >>> FRAC_W;
   endfunction

   function automatic logic signed [COORD_W-1:0] clamp_coord(input int v);
      if (v > 32767)
         return 16'sh7FFF;
      if (v < -32768)
         return 16'sh8000;
      return 16'(v);
   endfunction

   // Moves the pen for one character; returns 1 when a glyph is placed.
   function automatic bit place_char(input logic [CHAR_BITS-1:0] code,
                                     input logic first,
                                     input logic signed [COORD_W-1:0] sx,
                                     input logic signed [COORD_W-1:0] sy,
                                     output placement_type r);
      bit  known;
      int  drop;
      logic [GLYPH_W_BITS-1:0]   w;
      logic [ATLAS_POS_BITS-1:0] cx;
      logic [ATLAS_POS_BITS-1:0] cy;
      r = '0;
      known = 1'b0;
      drop = 0;
      w = '0;
      cx = '0;
      cy = '0;
      if (first) begin
         pen_x = sx;
         line_x = sx;
         pen_y = sy;
      end
      if (code == CHAR_NEWLINE) begin
         pen_y = clamp_coord(int'(pen_y) + scaled_by(20));
         pen_x = line_x;
         return 1'b0;
      end
      if (code == CHAR_SPACE) begin
         known = 1'b1;
         cx = SPACE_SRC_X;
         cy = SPACE_SRC_Y;
         w = SPACE_W;
      end else begin
         for (int i = 0; i < GLYPH_COUNT && !known; i++) begin
            if (ATLAS_CHARS[8*(GLYPH_COUNT-1-i) +: 8] == code) begin
               known = 1'b1;
               cx = 7'(16 * (i % 8));
               cy = 7'(16 * (i / 8));
               w = CELL_WIDTH[i];
            end
         end
      end
      if (!known)
         return 1'b0;
      if (code == CHAR_LO_P || code == CHAR_LO_Q || code == CHAR_LO_Y ||
          code == CHAR_LO_G)
         drop = scaled_by(4);
      else if (code == CHAR_LO_J)
         drop = scaled_by(3);
      r.src_x = cx;
      r.src_y = cy;
      r.src_w = w;
      r.dst_x = pen_x;
      r.dst_y = clamp_coord(int'(pen_y) + drop);
      r.dst_w = 8'(scaled_by(int'(w)));
      r.dst_h = 8'(scaled_by(15));
      pen_x = clamp_coord(int'(pen_x) + scaled_by(int'(w)));
      return 1'b1;
   endfunction

   function automatic logic signed [COORD_W-1:0] rand_coord();
      case ($urandom_range(0, 4))
         0: return 16'(32767 - int'($urandom_range(0, 400)));
         1: return 16'(-32768 + int'($urandom_range(0, 400)));
         default: return 16'($urandom);
      endcase
   endfunction

   // Text content: mostly atlas glyphs, with descenders, newlines and some
   // codes that may have no glyph at all.
   function automatic logic [CHAR_BITS-1:0] rand_char();
      int pick;
      int idx;
      pick = $urandom_range(0, 99);
      if (pick < 10)
         return CHAR_NEWLINE;
      if (pick < 14)
         return 8'($urandom);
      if (pick < 24) begin
         case ($urandom_range(0, 4))
            0: return CHAR_LO_P;
            1: return CHAR_LO_Q;
            2: return CHAR_LO_Y;
            3: return CHAR_LO_G;
            default: return CHAR_LO_J;
         endcase
      end
      idx = $urandom_range(0, GLYPH_COUNT);
      if (idx == GLYPH_COUNT)
         return CHAR_SPACE;
      return ATLAS_CHARS[8*(GLYPH_COUNT-1-idx) +: 8];
   endfunction

   task automatic send_char(input logic [CHAR_BITS-1:0] code, input logic first,
                            input logic signed [COORD_W-1:0] sx,
                            input logic signed [COORD_W-1:0] sy,
                            input logic typed, input placement_type want);
      placement_type r;
      int            gap_pct;
      gap_pct = (idle_mode == IDLE_SENDER) ? 87 : (idle_mode == IDLE_BOTH) ? 6 : 0;
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_if.valid <= 1'b0;
         do
            @(posedge clock);
         while ($urandom_range(0, 99) < gap_pct);
      end
      req_if.valid         <= 1'b1;
      req_if.char_code     <= code;
      req_if.first_of_text <= first;
      req_if.start_x       <= sx;
      req_if.start_y       <= sy;
      do
         @(posedge clock);
      while (req_if.ready !== 1'b1);
      accepted_requests++;
      if (place_char(code, first, sx, sy, r)) begin
         placements.push_back(typed ? want : r);
         layout_items++;
      end else if (code == CHAR_NEWLINE || first) begin
         layout_items++;
      end
      if (code == CHAR_NEWLINE)
         newlines++;
   endtask

   // The scale may change only with the pipeline empty, including requests
   // that carry no placement.
   task automatic set_scale(input logic [SCALE_W-1:0] value);
      req_if.valid <= 1'b0;
      while (placements.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      scale = value;
   endtask

   task automatic check_field(input string name, input int want_v, input int got_v);
      if (want_v != got_v) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      case (idle_mode)
         IDLE_RECEIVER: rsp_if.ready <= ($urandom_range(0, 99) >= 87);
         IDLE_BOTH:     rsp_if.ready <= ($urandom_range(0, 99) >= 6);
         default:       rsp_if.ready <= 1'b1;
      endcase
   end

   always @(posedge clock) begin : placement_monitor
      placement_type want;
      if (reset !== 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (placements.size() == 0) begin
            $display("%0t: placement with none expected, src (%0d,%0d) dst (%0d,%0d)",
                     $time, rsp_if.src_x, rsp_if.src_y, rsp_if.dst_x, rsp_if.dst_y);
            mismatches++;
         end else begin
            want = placements.pop_front();
            placements_checked++;
            check_field("src_x", want.src_x, rsp_if.src_x);
            check_field("src_y", want.src_y, rsp_if.src_y);
            check_field("src_w", want.src_w, rsp_if.src_w);
            check_field("dst_x", want.dst_x, rsp_if.dst_x);
            check_field("dst_y", want.dst_y, rsp_if.dst_y);
            check_field("dst_w", want.dst_w, rsp_if.dst_w);
            check_field("dst_h", want.dst_h, rsp_if.dst_h);
         end
      end
   end

   always @(posedge clock) begin
      if (reset !== 1'b0 || (req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: nothing moved on either channel for %0d cycles",
                  $time, WATCHDOG_LIMIT);
         $display("tb: failure");
         $finish;
      end
   end

   initial begin : stimulus
      int                 base;
      logic [SCALE_W-1:0] phase_scale;
      reset                <= 1'b1;
      req_if.valid         <= 1'b0;
      req_if.char_code     <= '0;
      req_if.first_of_text <= 1'b0;
      req_if.start_x       <= '0;
      req_if.start_y       <= '0;
      csr_we               <= 1'b0;
      csr_wdata            <= '0;
      pen_x  = '0;
      pen_y  = '0;
      line_x = '0;
      scale  = SCALE_W'(SCALE_ONE);
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i])
         send_char(DIRECTED[i].code, DIRECTED[i].first, DIRECTED[i].start_x,
                   DIRECTED[i].start_y, DIRECTED[i].typed, DIRECTED[i].want);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: phase_scale = SCALE_W'(SCALE_MAX);
            1: phase_scale = '0;
            2: phase_scale = SCALE_W'(1);
            3: phase_scale = SCALE_W'(SCALE_MAX);
            4: phase_scale = SCALE_W'(SCALE_ONE / 2);
            5: phase_scale = SCALE_W'(SCALE_ONE);
            default: phase_scale = SCALE_W'($urandom_range(1, SCALE_MAX - 1));
         endcase
         set_scale(phase_scale);
         idle_mode = idle_mode_type'(phase % 4);
         base = layout_items;
         while (layout_items - base < ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 9) == 0) begin
               // Noise: any code, any flag, any start.
               repeat ($urandom_range(1, 5))
                  send_char(8'($urandom), 1'($urandom), 16'($urandom),
                            16'($urandom), 1'b0, '0);
            end else begin
               send_char(rand_char(), 1'b1, rand_coord(), rand_coord(), 1'b0, '0);
               repeat ($urandom_range(1, 40))
                  send_char(rand_char(), 1'b0, rand_coord(), rand_coord(), 1'b0, '0);
            end
         end
      end

      req_if.valid <= 1'b0;
      idle_mode = IDLE_NONE;
      while (placements.size() != 0)
         @(posedge clock);
      repeat (2 * DRAIN_CYCLES) @(posedge clock);

      $display("summary: %0d requests accepted, %0d placements checked, %0d newlines",
               accepted_requests, placements_checked, newlines);
      $display("summary: %0d scale settings from zero to full range, four idle patterns",
               PHASE_COUNT + 1);
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule : tb_glyph_atlas_text_layout_top

[filelist.f]
rtl/core/gal_pkg.sv
rtl/core/gal_req_if.sv
rtl/core/gal_rsp_if.sv
rtl/core/gal_glyph_decode.sv
rtl/core/glyph_atlas_text_layout_top.sv
test/tb_glyph_atlas_text_layout_top.sv
